// File: sv/pts_pkg.sv
// Package for the priority task scheduler: widths, codes and shared structs.
package pts_pkg;

    localparam int TASK_COUNT_DEF = 8;
    localparam int DELAY_BITS_DEF = 16;
    localparam int ID_W           = 3;
    localparam int PRIO_W         = 8;
    localparam int TICKS_W        = 16;
    localparam int CMD_W          = 2;
    localparam int COUNT_W        = 4;
    localparam int FIFO_DEPTH     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 2'd0,
        CMD_SWITCH = 2'd1,
        CMD_DELAY  = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_SUSPENDED = 2'd0,
        ST_READY     = 2'd1,
        ST_RUNNING   = 2'd2,
        ST_BLOCKED   = 2'd3
    } status_t;

    // Input item
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ID_W-1:0]    task_id;
        logic [PRIO_W-1:0]  task_priority_in;
        logic               start_ready;
        logic [TICKS_W-1:0] ticks;
    } cmd_item_t;

    // Result item
    typedef struct packed {
        logic [ID_W-1:0]    running_task;
        logic               running_valid;
        logic               error;
        logic [COUNT_W-1:0] ready_count;
    } res_item_t;

endpackage

// File: sv/pts_if.sv
// Valid/ready channel interfaces for commands and results.
interface pts_cmd_if;
    import pts_pkg::*;
    logic      valid;
    logic      ready;
    cmd_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pts_res_if;
    import pts_pkg::*;
    logic      valid;
    logic      ready;
    res_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/pts_front.sv
// Front end: accepts commands, decodes them and pushes them into a short queue.
module pts_front
(
    input  logic               clk,
    input  logic               rst_n,
    pts_cmd_if.sink            cmd_in,
    output pts_pkg::cmd_item_t q_data,
    output logic               q_valid,
    input  logic               q_pop
);
    import pts_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    cmd_item_t          mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     fill_reg;
    logic               push;
    cmd_item_t          clean;

    assign cmd_in.ready = (fill_reg != (PTR_W+1)'(FIFO_DEPTH));
    assign push         = cmd_in.valid && cmd_in.ready;
    assign q_valid      = (fill_reg != '0);
    assign q_data       = mem[rd_ptr_reg];

    // Classify: fields a command does not use are zeroed
    always_comb
    begin
        clean = cmd_in.data;
        if (cmd_in.data.cmd != CMD_CREATE)
        begin
            clean.task_id          = '0;
            clean.task_priority_in = '0;
            clean.start_ready      = 1'b0;
        end
        if (cmd_in.data.cmd == CMD_SWITCH || cmd_in.data.cmd == CMD_TICK)
            clean.ticks = '0;
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= clean;
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg <= fill_reg + (PTR_W+1)'(push) - (PTR_W+1)'(q_pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg == (PTR_W+1)'(FIFO_DEPTH) |-> !push)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> fill_reg != '0)
        else $error("queue underflow");
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !q_pop |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("fill count");

endmodule

// File: sv/pts_back.sv
// Back end: sequencer that executes commands on the task table and ready queue.
module pts_back
#(
    parameter int TASK_COUNT = pts_pkg::TASK_COUNT_DEF,
    parameter int DELAY_BITS = pts_pkg::DELAY_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  pts_pkg::cmd_item_t q_data,
    input  logic               q_valid,
    output logic               q_pop,
    pts_res_if.source          res_out
);
    import pts_pkg::*;

    localparam int TI_W  = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam int LEN_W = $clog2(TASK_COUNT + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RM_SCAN, S_RM_SHIFT, S_CREATE, S_INS_SCAN, S_INS_SHIFT,
        S_SW_HEAD, S_TICK, S_RESULT
    } state_t;

    typedef enum logic [1:0] {
        RET_CREATE, RET_SWITCH, RET_TICK
    } ret_t;

    state_t                 state_reg;
    ret_t                   ret_reg;
    cmd_item_t              item_reg;
    logic [PRIO_W-1:0]      prio_reg   [TASK_COUNT];
    status_t                status_reg [TASK_COUNT];
    logic [DELAY_BITS-1:0]  delay_reg  [TASK_COUNT];
    logic [TI_W-1:0]        order_reg  [TASK_COUNT];
    logic [LEN_W-1:0]       len_reg;
    logic [TI_W-1:0]        cur_reg;
    logic                   present_reg;
    logic                   err_reg;
    logic [LEN_W-1:0]       pos_reg;
    logic [TI_W-1:0]        tgt_reg;
    logic [LEN_W-1:0]       scan_reg;
    logic                   out_valid_reg;
    res_item_t              out_reg;
    logic [TI_W-1:0]        cid;
    logic                   id_ok;

    // Next tick position after an insert resumes one past the woken task
    function automatic logic [LEN_W-1:0] tgt_reg_next_scan(input logic [TI_W-1:0] t);
        return LEN_W'(t) + 1'b1;
    endfunction

    assign q_pop        = (state_reg == S_IDLE) && q_valid;
    assign res_out.valid = out_valid_reg;
    assign res_out.data  = out_reg;
    assign cid = TI_W'(item_reg.task_id);
    assign id_ok = ({{(32-ID_W){1'b0}}, item_reg.task_id} < 32'(TASK_COUNT));

    // Command sequencer: one queue position or one task per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= RET_CREATE;
            len_reg       <= '0;
            cur_reg       <= '0;
            present_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            err_reg       <= 1'b0;
            pos_reg       <= '0;
            tgt_reg       <= '0;
            scan_reg      <= '0;
            for (int i = 0; i < TASK_COUNT; i++)
            begin
                prio_reg[i]   <= '0;
                status_reg[i] <= ST_SUSPENDED;
                delay_reg[i]  <= '0;
            end
        end
        else
        begin
            if (res_out.valid && res_out.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg <= q_data;
                        err_reg  <= 1'b0;
                        pos_reg  <= '0;
                        scan_reg <= '0;
                        case (cmd_t'(q_data.cmd))
                            CMD_CREATE:
                            begin
                                ret_reg <= RET_CREATE;
                                tgt_reg <= TI_W'(q_data.task_id);
                                state_reg <= S_RM_SCAN;
                            end
                            CMD_SWITCH, CMD_DELAY:
                            begin
                                ret_reg <= RET_SWITCH;
                                tgt_reg <= cur_reg;
                                if (present_reg && q_data.cmd == CMD_DELAY)
                                begin
                                    delay_reg[cur_reg]  <= DELAY_BITS'(q_data.ticks);
                                    status_reg[cur_reg] <= ST_BLOCKED;
                                    state_reg <= S_SW_HEAD;
                                end
                                else if (present_reg && status_reg[cur_reg] == ST_RUNNING)
                                begin
                                    status_reg[cur_reg] <= ST_READY;
                                    state_reg <= S_INS_SCAN;
                                end
                                else
                                    state_reg <= S_SW_HEAD;
                            end
                            default:
                            begin
                                ret_reg   <= RET_TICK;
                                state_reg <= S_TICK;
                            end
                        endcase
                    end
                end
                // Find the task to take out of the queue
                S_RM_SCAN:
                begin
                    if (!id_ok || status_reg[cid] != ST_READY || pos_reg >= len_reg)
                        state_reg <= S_CREATE;
                    else if (order_reg[pos_reg[TI_W-1:0]] == tgt_reg)
                        state_reg <= S_RM_SHIFT;
                    else
                        pos_reg <= pos_reg + 1'b1;
                end
                // Close the gap one entry a cycle
                S_RM_SHIFT:
                begin
                    if (pos_reg + 1'b1 < len_reg)
                    begin
                        order_reg[pos_reg[TI_W-1:0]] <=
                            order_reg[TI_W'(pos_reg + 1'b1)];
                        pos_reg <= pos_reg + 1'b1;
                    end
                    else
                    begin
                        len_reg <= len_reg - 1'b1;
                        state_reg <= (ret_reg == RET_SWITCH) ? S_RESULT : S_CREATE;
                    end
                end
                S_CREATE:
                begin
                    if (!id_ok)
                        state_reg <= S_RESULT;
                    else
                    begin
                        if (present_reg && cur_reg == cid)
                            present_reg <= 1'b0;
                        prio_reg[cid]  <= item_reg.task_priority_in;
                        delay_reg[cid] <= DELAY_BITS'(item_reg.ticks);
                        pos_reg <= '0;
                        if (item_reg.start_ready)
                        begin
                            status_reg[cid] <= ST_READY;
                            state_reg <= S_INS_SCAN;
                        end
                        else
                        begin
                            status_reg[cid] <= ST_SUSPENDED;
                            state_reg <= S_RESULT;
                        end
                    end
                end
                // Find the insert position behind equal priorities
                S_INS_SCAN:
                begin
                    if (pos_reg < len_reg &&
                        prio_reg[tgt_reg] <= prio_reg[order_reg[pos_reg[TI_W-1:0]]])
                        pos_reg <= pos_reg + 1'b1;
                    else if (len_reg >= LEN_W'(TASK_COUNT))
                        state_reg <= (ret_reg == RET_SWITCH) ? S_SW_HEAD
                                   : (ret_reg == RET_TICK) ? S_TICK : S_RESULT;
                    else
                    begin
                        scan_reg  <= len_reg;
                        state_reg <= S_INS_SHIFT;
                    end
                end
                // Open the slot from the tail down
                S_INS_SHIFT:
                begin
                    if (scan_reg > pos_reg)
                    begin
                        order_reg[scan_reg[TI_W-1:0]] <=
                            order_reg[TI_W'(scan_reg - 1'b1)];
                        scan_reg <= scan_reg - 1'b1;
                    end
                    else
                    begin
                        order_reg[pos_reg[TI_W-1:0]] <= tgt_reg;
                        len_reg <= len_reg + 1'b1;
                        case (ret_reg)
                            RET_SWITCH: state_reg <= S_SW_HEAD;
                            RET_TICK:   state_reg <= S_TICK;
                            default:    state_reg <= S_RESULT;
                        endcase
                        scan_reg <= tgt_reg_next_scan(tgt_reg);
                    end
                end
                // Take the head of the queue
                S_SW_HEAD:
                begin
                    if (len_reg == '0)
                    begin
                        present_reg <= 1'b0;
                        err_reg     <= 1'b1;
                        state_reg   <= S_RESULT;
                    end
                    else
                    begin
                        status_reg[order_reg[0]] <= ST_RUNNING;
                        cur_reg     <= order_reg[0];
                        present_reg <= 1'b1;
                        tgt_reg     <= order_reg[0];
                        pos_reg     <= '0;
                        state_reg   <= S_RM_SHIFT;
                    end
                end
                // Walk tasks in index order
                S_TICK:
                begin
                    if (scan_reg >= LEN_W'(TASK_COUNT))
                        state_reg <= S_RESULT;
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                        if (status_reg[scan_reg[TI_W-1:0]] == ST_BLOCKED &&
                            delay_reg[scan_reg[TI_W-1:0]] <= DELAY_BITS'(1))
                        begin
                            delay_reg[scan_reg[TI_W-1:0]]  <= '0;
                            status_reg[scan_reg[TI_W-1:0]] <= ST_READY;
                            tgt_reg   <= scan_reg[TI_W-1:0];
                            pos_reg   <= '0;
                            state_reg <= S_INS_SCAN;
                        end
                        else if (status_reg[scan_reg[TI_W-1:0]] == ST_BLOCKED)
                            delay_reg[scan_reg[TI_W-1:0]] <=
                                delay_reg[scan_reg[TI_W-1:0]] - 1'b1;
                    end
                end
                S_RESULT:
                begin
                    if (!out_valid_reg || res_out.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.running_task  <= present_reg ? ID_W'(cur_reg) : '0;
                        out_reg.running_valid <= present_reg;
                        out_reg.error         <= err_reg;
                        out_reg.ready_count   <= COUNT_W'(len_reg);
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(TASK_COUNT))
        else $error("queue length out of range");
    a_err_no_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.error |-> !out_reg.running_valid)
        else $error("error with running task");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg != S_IDLE)
        else $error("pop without work");

endmodule

// File: sv/priority_task_scheduler.sv
// A switch that requeues the running task first inserts it into the queue, then takes the head.
// A tick walks all N tasks, one per cycle, plus one queue insert per woken task.
// One result per command; the front queue lets new commands be accepted while the sequencer is busy.
// The sequencer in the back end sets the rate; the front queue holds two items.
// Reset: all tasks suspended, queue empty, no task running, priorities zero.
module priority_task_scheduler
#(
    parameter int TASK_COUNT = pts_pkg::TASK_COUNT_DEF,
    parameter int DELAY_BITS = pts_pkg::DELAY_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    pts_cmd_if.sink    cmd_in,
    pts_res_if.source  res_out
);
    import pts_pkg::*;

    cmd_item_t q_data;
    logic      q_valid;
    logic      q_pop;

    pts_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_in (cmd_in),
        .q_data (q_data),
        .q_valid(q_valid),
        .q_pop  (q_pop)
    );

    pts_back #(.TASK_COUNT(TASK_COUNT), .DELAY_BITS(DELAY_BITS)) u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_data (q_data),
        .q_valid(q_valid),
        .q_pop  (q_pop),
        .res_out(res_out)
    );

endmodule

// File: bench/priority_task_scheduler_tb.sv
// Testbench for the priority task scheduler: directed and random commands checked against a scheduler model.
module priority_task_scheduler_tb;
    import pts_pkg::*;

    localparam int NTASK     = 8;
    localparam int RAND_CMDS = 1950;
    localparam int MAX_CYC   = 4000000;

    logic clk;
    logic rst_n;

    pts_cmd_if cmd_ch();
    pts_res_if res_ch();

    priority_task_scheduler dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_in  (cmd_ch.sink),
        .res_out (res_ch.source)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Scheduler model state
    logic [7:0]  m_prio [NTASK];
    status_t     m_stat [NTASK];
    logic [15:0] m_delay [NTASK];
    int          m_queue [$];
    int          m_cur;
    bit          m_present;

    cmd_item_t   pending_cmds [$];
    res_item_t   expected_res [$];
    int          errors;
    int          cycles;
    int          checked;
    bit          hold_off;

    task automatic report(input string what, input res_item_t got, input res_item_t want);
        errors++;
        $display("tb: mismatch %s: got %h want %h", what, got, want);
    endtask

    // Priority order with equal priorities kept first-in-first-out
    function automatic void enqueue_task(input int t);
        int pos;
        pos = 0;
        while (pos < m_queue.size() && m_prio[t] <= m_prio[m_queue[pos]])
            pos++;
        m_queue.insert(pos, t);
    endfunction

    function automatic void dequeue_task(input int t);
        for (int k = 0; k < m_queue.size(); k++)
        begin
            if (m_queue[k] == t)
            begin
                m_queue.delete(k);
                break;
            end
        end
    endfunction

    function automatic bit switch_task();
        if (m_present && m_stat[m_cur] == ST_RUNNING)
        begin
            m_stat[m_cur] = ST_READY;
            enqueue_task(m_cur);
        end
        if (m_queue.size() == 0)
        begin
            m_present = 1'b0;
            return 1'b1;
        end
        m_cur = m_queue.pop_front();
        m_stat[m_cur] = ST_RUNNING;
        m_present = 1'b1;
        return 1'b0;
    endfunction

    function automatic res_item_t schedule_step(input cmd_item_t c);
        res_item_t r;
        bit err;
        int id;
        err = 1'b0;
        id = c.task_id;
        case (cmd_t'(c.cmd))
            CMD_CREATE:
            begin
                if (m_stat[id] == ST_READY)
                    dequeue_task(id);
                if (m_present && m_cur == id)
                    m_present = 1'b0;
                m_prio[id]  = c.task_priority_in;
                m_delay[id] = c.ticks;
                if (c.start_ready)
                begin
                    m_stat[id] = ST_READY;
                    enqueue_task(id);
                end
                else
                    m_stat[id] = ST_SUSPENDED;
            end
            CMD_SWITCH:
                err = switch_task();
            CMD_DELAY:
            begin
                if (m_present)
                begin
                    m_delay[m_cur] = c.ticks;
                    m_stat[m_cur]  = ST_BLOCKED;
                end
                err = switch_task();
            end
            default:
            begin
                for (int i = 0; i < NTASK; i++)
                begin
                    if (m_stat[i] == ST_BLOCKED)
                    begin
                        if (m_delay[i] != 0)
                            m_delay[i]--;
                        if (m_delay[i] == 0)
                        begin
                            m_stat[i] = ST_READY;
                            enqueue_task(i);
                        end
                    end
                end
            end
        endcase
        r.running_task  = m_present ? m_cur[2:0] : '0;
        r.running_valid = m_present;
        r.error         = err;
        r.ready_count   = COUNT_W'(m_queue.size());
        return r;
    endfunction

    function automatic cmd_item_t make_cmd(input cmd_t op, input int id, input int pr,
                                           input bit st, input int tk);
        cmd_item_t c;
        c.cmd              = op;
        c.task_id          = ID_W'(id);
        c.task_priority_in = PRIO_W'(pr);
        c.start_ready      = st;
        c.ticks            = TICKS_W'(tk);
        return c;
    endfunction

    // Random command; short delays mostly so tasks wake up again
    function automatic cmd_item_t rand_cmd();
        int sel;
        int tk;
        sel = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0)
            tk = $urandom_range(0, 65535);
        else
            tk = $urandom_range(0, 4);
        if (sel < 20)
            return make_cmd(CMD_CREATE, $urandom_range(0, 7),
                            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 3) * 85,
                            $urandom_range(0, 5) != 0, tk);
        else if (sel < 50)
            return make_cmd(CMD_SWITCH, $urandom_range(0, 7), $urandom_range(0, 255),
                            $urandom_range(0, 1), $urandom_range(0, 65535));
        else if (sel < 68)
            return make_cmd(CMD_DELAY, $urandom_range(0, 7), $urandom_range(0, 255),
                            $urandom_range(0, 1), tk);
        else
            return make_cmd(CMD_TICK, $urandom_range(0, 7), $urandom_range(0, 255),
                            $urandom_range(0, 1), $urandom_range(0, 65535));
    endfunction

    // Driver: bursts with random gaps
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.data  <= '0;
            burst_left   <= 0;
            gap_left     <= 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                expected_res.push_back(schedule_step(cmd_ch.data));
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left     <= gap_left - 1;
                    cmd_ch.valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0 && !hold_off)
                begin
                    cmd_ch.valid <= 1'b1;
                    cmd_ch.data  <= pending_cmds.pop_front();
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stall pattern
    logic [7:0] stall_pat;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_pat    <= 8'hff;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_res.size() == 0)
                    report("unexpected result", res_ch.data, '0);
                else
                begin
                    res_item_t want;
                    want = expected_res.pop_front();
                    checked++;
                    if (res_ch.data.running_task != want.running_task)
                        report("running_task", res_ch.data, want);
                    if (res_ch.data.running_valid != want.running_valid)
                        report("running_valid", res_ch.data, want);
                    if (res_ch.data.error != want.error)
                        report("error", res_ch.data, want);
                    if (res_ch.data.ready_count != want.ready_count)
                        report("ready_count", res_ch.data, want);
                end
            end
            if (cycles % 512 == 0)
                stall_pat <= (cycles % 2048 < 512) ? 8'hff : 8'($urandom());
            else
                stall_pat <= {stall_pat[6:0], stall_pat[7]};
            res_ch.ready <= stall_pat[0];
        end
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYC)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        errors    = 0;
        cycles    = 0;
        checked   = 0;
        hold_off  = 0;
        m_present = 0;
        m_cur     = 0;
        for (int i = 0; i < NTASK; i++)
        begin
            m_prio[i]  = '0;
            m_stat[i]  = ST_SUSPENDED;
            m_delay[i] = '0;
        end
        rst_n = 1'b0;

        // Directed: empty queue, delay with nothing running, field extremes
        pending_cmds.push_back(make_cmd(CMD_SWITCH, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_DELAY, 7, 255, 1, 65535));
        pending_cmds.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_CREATE, 0, 255, 1, 65535));
        pending_cmds.push_back(make_cmd(CMD_CREATE, 7, 0, 1, 0));
        pending_cmds.push_back(make_cmd(CMD_CREATE, 3, 128, 1, 0));
        pending_cmds.push_back(make_cmd(CMD_CREATE, 5, 128, 1, 0));  // equal priority, FIFO
        pending_cmds.push_back(make_cmd(CMD_CREATE, 6, 1, 0, 1));    // suspended
        pending_cmds.push_back(make_cmd(CMD_SWITCH, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_CREATE, 3, 200, 1, 0));  // re-create queued task
        pending_cmds.push_back(make_cmd(CMD_DELAY, 0, 0, 0, 0));     // delay of zero
        pending_cmds.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_SWITCH, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_CREATE, 3, 50, 1, 2));   // re-create queued task at lower priority
        pending_cmds.push_back(make_cmd(CMD_DELAY, 0, 0, 0, 2));
        pending_cmds.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_SWITCH, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_SWITCH, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_SWITCH, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_SWITCH, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_SWITCH, 0, 0, 0, 0));
        for (int i = 0; i < RAND_CMDS; i++)
            pending_cmds.push_back(rand_cmd());

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Pause once mid-run until the block has drained
        wait (pending_cmds.size() < RAND_CMDS / 2);
        @(posedge clk);
        hold_off <= 1'b1;
        wait (!cmd_ch.valid && expected_res.size() == 0);
        @(posedge clk);
        hold_off <= 1'b0;

        wait (pending_cmds.size() == 0);
        wait (!cmd_ch.valid && expected_res.size() == 0);
        repeat (100) @(posedge clk);

        $display("tb: ran %0d commands of all four kinds over 8 tasks, %0d results checked",
                 RAND_CMDS + 22, checked);
        if (errors == 0 && expected_res.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
